// ----- src/sha_pkg.sv -----
// Shared types, constants and the round constant table for the SHA-256 engine.
package sha_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned NumH   = 8;
  localparam int unsigned NumWin = 16;
  localparam int unsigned TotalW = 61;

  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;

  localparam logic [WordW-1:0] H_INIT [NumH] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Control from the sequencer to the schedule and round units.
  typedef struct packed {
    logic       push;
    logic [7:0] push_byte;
    logic       load;
    logic       step;
    logic       accum;
    logic       restart;
  } sha_ctl_t;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    round_k = k;
  endfunction

endpackage

// ----- src/sha_sched.sv -----
// Byte packer and sixteen-word message schedule window.
module sha_sched (
  input  logic              clk,
  input  sha_pkg::sha_ctl_t ctl,
  input  logic [1:0]        byte_pos,
  output logic [31:0]       wt
);

  logic [23:0] acc_r;
  logic [31:0] win_r [sha_pkg::NumWin];
  logic [31:0] new_w;
  logic [31:0] s0;
  logic [31:0] s1;

  assign s0 = sha_pkg::ror32(win_r[1], 7) ^ sha_pkg::ror32(win_r[1], 18) ^ (win_r[1] >> 3);
  assign s1 = sha_pkg::ror32(win_r[14], 17) ^ sha_pkg::ror32(win_r[14], 19)
            ^ (win_r[14] >> 10);
  assign new_w = win_r[0] + s0 + win_r[9] + s1;
  assign wt = win_r[0];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      acc_r <= {acc_r[15:0], ctl.push_byte};
    end
    // The window shifts when a packed word completes or when a round consumes a word.
    if ((ctl.push && (byte_pos == 2'd3)) || ctl.step) begin
      for (int i = 0; i < sha_pkg::NumWin - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[sha_pkg::NumWin-1] <= ctl.step ? new_w : {acc_r, ctl.push_byte};
    end
  end

endmodule

// ----- src/sha_round.sv -----
// Working variables, one compression round per step, and the chaining words.
module sha_round (
  input  logic              clk,
  input  logic              rst_n,
  input  sha_pkg::sha_ctl_t ctl,
  input  logic [31:0]       kt,
  input  logic [31:0]       wt,
  input  logic [2:0]        rd_idx,
  output logic [31:0]       rd_word
);

  logic [31:0] chain_r [sha_pkg::NumH];
  logic [31:0] v_r     [sha_pkg::NumH];
  logic [31:0] t1;
  logic [31:0] t2;

  assign t1 = v_r[7] + (sha_pkg::ror32(v_r[4], 6) ^ sha_pkg::ror32(v_r[4], 11)
            ^ sha_pkg::ror32(v_r[4], 25)) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + kt + wt;
  assign t2 = (sha_pkg::ror32(v_r[0], 2) ^ sha_pkg::ror32(v_r[0], 13)
            ^ sha_pkg::ror32(v_r[0], 22))
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign rd_word = chain_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.restart) begin
      for (int i = 0; i < sha_pkg::NumH; i++) begin
        chain_r[i] <= sha_pkg::H_INIT[i];
      end
    end else if (ctl.accum) begin
      for (int i = 0; i < sha_pkg::NumH; i++) begin
        chain_r[i] <= chain_r[i] + v_r[i];
      end
    end
    if (ctl.load) begin
      for (int i = 0; i < sha_pkg::NumH; i++) begin
        v_r[i] <= chain_r[i];
      end
    end else if (ctl.step) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

endmodule

// ----- src/sha256_hash_engine_top.sv -----
// SHA-256 engine top level: byte intake, padding sequencer and digest output.
//
// Channel | Direction | Beat contents
// in_     | input     | data_byte, has_byte, end_of_message
// out_    | output    | digest_word, word_index, last_word (eight beats per message)
//
// Every 64th byte starts the rounds and the chaining add, all run through the
// one shared round unit. Closing a message pushes the pad and length bytes at
// one per cycle (9 to 72), running the rounds for each block they complete,
// then eight output beats.
// Synchronous reset loads the initial hash values and clears the counters.
// in_stall is high in all states but idle: padding, rounds, chaining add, output.
module sha256_hash_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  typedef enum logic [2:0] {S_IDLE, S_PAD, S_ROUND, S_FINAL, S_OUT} state_t;

  state_t                       state_r, state_nxt;
  logic [5:0]                   fill_r, fill_nxt;
  logic [5:0]                   round_r, round_nxt;
  logic [sha_pkg::TotalW-1:0]   total_r, total_nxt;
  logic [3:0]                   len_r, len_nxt;
  logic                         sent80_r, sent80_nxt;
  logic                         pad_act_r, pad_act_nxt;
  logic [2:0]                   idx_r, idx_nxt;
  logic                         in_acc;
  logic                         out_acc;
  logic [63:0]                  len_shift;
  logic                         pad_zero;
  logic                         blk_full;
  logic [31:0]                  wt;
  sha_pkg::sha_ctl_t            ctl;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_word_index = idx_r;
  assign out_last_word = (idx_r == 3'd7);

  assign len_shift = {total_r, 3'b000} << {len_r[2:0], 3'b000};
  assign pad_zero  = (len_r == 4'd0) && (fill_r != sha_pkg::LenOffset);

  always_comb begin
    ctl = '0;
    if (state_r == S_IDLE) begin
      ctl.push      = in_acc && in_has_byte;
      ctl.push_byte = in_data_byte;
    end else if (state_r == S_PAD) begin
      ctl.push      = 1'b1;
      ctl.push_byte = !sent80_r ? sha_pkg::PadByte : (pad_zero ? 8'h00 : len_shift[63:56]);
    end
    blk_full    = ctl.push && (fill_r == 6'd63);
    ctl.load    = blk_full;
    ctl.step    = (state_r == S_ROUND);
    ctl.accum   = (state_r == S_FINAL);
    ctl.restart = out_acc && out_last_word;
  end

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = ctl.push ? fill_r + 6'd1 : fill_r;
    round_nxt   = round_r;
    total_nxt   = total_r;
    len_nxt     = len_r;
    sent80_nxt  = sent80_r;
    pad_act_nxt = pad_act_r;
    idx_nxt     = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_has_byte) begin
            total_nxt = total_r + sha_pkg::TotalW'(1);
          end
          pad_act_nxt = in_end_of_message;
          if (blk_full) begin
            state_nxt = S_ROUND;
          end else if (in_end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (!sent80_r) begin
          sent80_nxt = 1'b1;
        end else if (!pad_zero) begin
          len_nxt = len_r + 4'd1;
        end
        if (blk_full) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        round_nxt = round_r + 6'd1;
        if (round_r == 6'd63) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        if (!pad_act_r) begin
          state_nxt = S_IDLE;
        end else if (len_r == 4'd8) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_PAD;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (out_last_word) begin
            state_nxt   = S_IDLE;
            total_nxt   = '0;
            len_nxt     = '0;
            sent80_nxt  = 1'b0;
            pad_act_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      round_r   <= '0;
      total_r   <= '0;
      len_r     <= '0;
      sent80_r  <= 1'b0;
      pad_act_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      round_r   <= round_nxt;
      total_r   <= total_nxt;
      len_r     <= len_nxt;
      sent80_r  <= sent80_nxt;
      pad_act_r <= pad_act_nxt;
      idx_r     <= idx_nxt;
    end
  end

  sha_sched u_sched (
    .clk      (clk),
    .ctl      (ctl),
    .byte_pos (fill_r[1:0]),
    .wt       (wt)
  );

  sha_round u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .kt      (sha_pkg::round_k(round_r)),
    .wt      (wt),
    .rd_idx  (idx_r),
    .rd_word (out_digest_word)
  );

  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while digest pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word_index)
      && $stable(out_digest_word)) else $error("stalled digest word changed");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_last_word |=> !out_valid && !in_stall && (fill_r == 6'd0))
    else $error("engine not idle after final digest word");

  a_round_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> !ctl.push) else $error("byte pushed during rounds");

endmodule

// ----- tb/tb_sha256_hash_engine_top.sv -----
// Self-checking testbench for the byte-serial SHA-256 engine.
`timescale 1ns / 100ps

module tb_sha256_hash_engine_top;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } msg_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  localparam int unsigned IdleLimit = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_has_byte;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha256_hash_engine_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_has_byte(in_has_byte),
    .in_end_of_message(in_end_of_message),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );

  msg_beat_t    pending_beats[$];
  digest_beat_t expected_words[$];

  logic [31:0] hash_state [8];
  logic [7:0]  blk_bytes [64];
  int unsigned blk_fill;
  logic [60:0] msg_len;

  int unsigned error_count;
  int unsigned beats_sent;
  int unsigned words_seen;
  int unsigned msgs_closed;
  int unsigned idle_cycles;
  logic        stim_done;

  localparam logic [31:0] KTab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HStart [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic absorb(input logic [7:0] b);
    blk_bytes[blk_fill] = b;
    blk_fill++;
    if (blk_fill == 64) begin
      compress_block();
      blk_fill = 0;
    end
  endtask

  // Updates the hash state for one beat and queues the digest words it closes.
  task automatic hash_beat(input msg_beat_t bt);
    logic [63:0] bit_len;
    digest_beat_t dw;
    if (bt.has_byte) begin
      absorb(bt.data_byte);
      msg_len = msg_len + 61'd1;
    end
    if (bt.end_of_message) begin
      bit_len = {msg_len, 3'b000};
      absorb(sha_pkg::PadByte);
      while (blk_fill != 56) absorb(8'h00);
      for (int i = 0; i < 8; i++) absorb(bit_len[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        dw.digest_word = hash_state[i];
        dw.word_index  = i[2:0];
        dw.last_word   = (i == 7);
        expected_words.push_back(dw);
      end
      for (int i = 0; i < 8; i++) hash_state[i] = HStart[i];
      blk_fill = 0;
      msg_len  = '0;
      msgs_closed++;
    end
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_message(input int unsigned nbytes, input bit empty_close);
    msg_beat_t bt;
    for (int unsigned i = 0; i < nbytes; i++) begin
      bt.data_byte      = 8'($urandom_range(0, 255));
      bt.has_byte       = 1'b1;
      bt.end_of_message = (i == nbytes - 1) && !empty_close;
      pending_beats.push_back(bt);
      // Noise beats with stray data bits that the block must ignore.
      if ($urandom_range(0, 19) == 0) begin
        bt.data_byte      = 8'($urandom_range(0, 255));
        bt.has_byte       = 1'b0;
        bt.end_of_message = 1'b0;
        pending_beats.push_back(bt);
      end
    end
    if (empty_close || nbytes == 0) begin
      bt.data_byte      = 8'($urandom_range(0, 255));
      bt.has_byte       = 1'b0;
      bt.end_of_message = 1'b1;
      pending_beats.push_back(bt);
    end
  endtask

  task automatic bt_drive(input msg_beat_t bt);
    in_valid          <= 1'b1;
    in_data_byte      <= bt.data_byte;
    in_has_byte       <= bt.has_byte;
    in_end_of_message <= bt.end_of_message;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    msg_beat_t bt;
    static int unsigned lens [2] = '{56, 64};
    rst_n = 1'b0;
    stim_done = 1'b0;
    for (int i = 0; i < 8; i++) hash_state[i] = HStart[i];
    blk_fill = 0;
    msg_len  = '0;
    // Directed: empty message, extreme bytes, idle beat, closing with no byte.
    bt = '{data_byte: 8'hff, has_byte: 1'b0, end_of_message: 1'b1};
    pending_beats.push_back(bt);
    bt = '{data_byte: 8'hff, has_byte: 1'b0, end_of_message: 1'b0};
    pending_beats.push_back(bt);
    bt = '{data_byte: 8'h00, has_byte: 1'b1, end_of_message: 1'b0};
    pending_beats.push_back(bt);
    bt = '{data_byte: 8'hff, has_byte: 1'b1, end_of_message: 1'b1};
    pending_beats.push_back(bt);
    bt = '{data_byte: 8'h61, has_byte: 1'b1, end_of_message: 1'b0};
    pending_beats.push_back(bt);
    bt = '{data_byte: 8'h00, has_byte: 1'b0, end_of_message: 1'b1};
    pending_beats.push_back(bt);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // Messages that cross the padding boundary and that fill a block exactly.
    for (int m = 0; m < 2; m++) add_message(lens[m], 1'($urandom_range(0, 1)));
    while (pending_beats.size() < 130)
      add_message($urandom_range(0, 20), $urandom_range(0, 3) == 0);
    stim_done = 1'b1;
  end

  // Driver: holds each beat until the block takes it.
  always @(posedge clk) begin
    static int unsigned gap = 0;
    if (!rst_n) begin
      in_valid          <= 1'b0;
      in_data_byte      <= '0;
      in_has_byte       <= 1'b0;
      in_end_of_message <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        hash_beat({in_data_byte, in_has_byte, in_end_of_message});
        beats_sent++;
      end
      if (gap > 0) begin
        gap--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        bt_drive(pending_beats.pop_front());
        gap = gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each digest word against the oldest expectation.
  always @(posedge clk) begin
    digest_beat_t exp_w;
    if (!rst_n) begin
      out_stall   <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected digest word %h index %0d", $time,
                   out_digest_word, out_word_index);
          error_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w != {out_digest_word, out_word_index, out_last_word}) begin
            $display("%0t: digest mismatch expected %h/%0d/%0d actual %h/%0d/%0d", $time,
                     exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                     out_digest_word, out_word_index, out_last_word);
            error_count++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      case ($urandom_range(0, 19))
        0:       out_stall <= 1'b1;
        1, 2, 3: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  initial begin
    error_count = 0;
    beats_sent  = 0;
    words_seen  = 0;
    msgs_closed = 0;
    @(posedge rst_n);
    while (!(stim_done && pending_beats.size() == 0 && !in_valid &&
             expected_words.size() == 0)) begin
      @(posedge clk);
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout after %0d idle cycles", idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
    repeat (200) @(posedge clk);
    if (expected_words.size() != 0) error_count++;
    $display("Sent %0d input beats closing %0d messages; checked %0d digest words.",
             beats_sent, msgs_closed, words_seen);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/sha_pkg.sv
src/sha_sched.sv
src/sha_round.sv
src/sha256_hash_engine_top.sv
tb/tb_sha256_hash_engine_top.sv
